// ===== rtl/bsr_pkg.sv =====
// Package for the byte stream reassembler: ring size, item op codes and
// sequencer states. No dependencies.
package bsr_pkg;

  // Ring size; must be a power of two (slot is the low bits of the position).
  localparam int unsigned Capacity = 1024;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned CntW     = SlotW + 1;

  localparam logic [1:0] OpStore = 2'd0;
  localparam logic [1:0] OpRead  = 2'd1;
  localparam logic [1:0] OpEmpty = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_STCHK,
    ST_ADV,
    ST_ADVCHK,
    ST_RDCHK,
    ST_FIN
  } state_e;

endpackage

// ===== rtl/byte_stream_reassembler_core.sv =====
// Byte stream reassembler: ring memory with per-slot valid bit, run by a
// small sequencer that checks and advances one slot per memory access.
// Depends on bsr_pkg.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------------------
//  in item  | start, busy             | op_i, position_i, value_byte_i, eof_i
//  result   | out_strobe_o (1 cycle)  | read_valid_o, read_byte_o,
//           |                         | assembled_up_to_o, pending_bytes_o,
//           |                         | stream_done_o
//
// Each item runs ST_EXEC, its check states, then ST_FIN: a read that pops a byte passes
// ST_RDCHK, a store in the window passes ST_STCHK, and a store that lands then loops
// ST_ADV/ST_ADVCHK over the bytes it assembles (one registered ring read per slot
// checked). The result strobes in the first cycle with busy low.
// After reset the sequencer clears all Capacity valid bits, one per cycle;
// busy stays high meanwhile.
// The result receiver cannot stall; results are never held back.
module byte_stream_reassembler_core
  import bsr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [31:0] position_i,
  input  logic [7:0]  value_byte_i,
  input  logic        eof_i,
  output logic        out_strobe_o,
  output logic        read_valid_o,
  output logic [7:0]  read_byte_o,
  output logic [31:0] assembled_up_to_o,
  output logic [10:0] pending_bytes_o,
  output logic        stream_done_o
);

  state_e state_q, state_d;

  // latched item
  logic [1:0]  op_q, op_d;
  logic [31:0] pos_q, pos_d;
  logic [7:0]  byte_q, byte_d;
  logic        eof_q, eof_d;

  // stream state
  logic [31:0]     ne_q, ne_d;
  logic [31:0]     fu_q, fu_d;
  logic [CntW-1:0] pend_q, pend_d;
  logic [31:0]     end_q, end_d;
  logic            known_q, known_d;
  logic            ended_q, ended_d;

  logic            rvalid_q, rvalid_d;
  logic [7:0]      rbyte_q, rbyte_d;
  logic            strobe_q, strobe_d;
  logic [SlotW-1:0] clr_q, clr_d;

  // ring: {valid, byte}
  logic [8:0]       mem [Capacity];
  logic             mem_we, mem_re;
  logic [SlotW-1:0] mem_waddr, mem_raddr;
  logic [8:0]       mem_wdata, rdata_q;

  logic [31:0] used, room, pos_off, end_gap;
  logic        has_room, in_win, can_adv, have_data;

  assign used      = ne_q - fu_q;
  assign has_room  = used < 32'(Capacity);
  assign room      = 32'(Capacity) - used;
  assign pos_off   = pos_q - ne_q;
  assign in_win    = has_room && (pos_off < room);
  assign can_adv   = has_room && (pend_q != '0);
  assign have_data = fu_q != ne_q;
  assign end_gap   = ne_q - end_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:   if (start) state_d = ST_EXEC;
      ST_EXEC: begin
        case (op_q)
          OpStore: state_d = in_win ? ST_STCHK : ST_FIN;
          OpRead:  state_d = have_data ? ST_RDCHK : ST_FIN;
          default: state_d = ST_FIN;
        endcase
      end
      ST_STCHK:  state_d = rdata_q[8] ? ST_FIN : ST_ADV;
      ST_ADV:    state_d = can_adv ? ST_ADVCHK : ST_FIN;
      ST_ADVCHK: state_d = rdata_q[8] ? ST_ADV : ST_FIN;
      ST_RDCHK:  state_d = ST_FIN;
      ST_FIN:    state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and ring control
  always_comb begin
    op_d     = op_q;
    pos_d    = pos_q;
    byte_d   = byte_q;
    eof_d    = eof_q;
    ne_d     = ne_q;
    fu_d     = fu_q;
    pend_d   = pend_q;
    end_d    = end_q;
    known_d  = known_q;
    ended_d  = ended_q;
    rvalid_d = rvalid_q;
    rbyte_d  = rbyte_q;
    strobe_d = 1'b0;
    clr_d    = clr_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = '0;
    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
      end
      ST_IDLE: begin
        if (start) begin
          op_d     = op_i;
          pos_d    = position_i;
          byte_d   = value_byte_i;
          eof_d    = eof_i;
          rvalid_d = 1'b0;
          rbyte_d  = '0;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OpStore: begin
            if (eof_q) begin
              end_d   = pos_q + 32'd1;
              known_d = 1'b1;
            end
            if (in_win) begin
              mem_re    = 1'b1;
              mem_raddr = pos_q[SlotW-1:0];
            end
          end
          OpRead: begin
            if (have_data) begin
              mem_re    = 1'b1;
              mem_raddr = fu_q[SlotW-1:0];
            end
          end
          OpEmpty: begin
            if (eof_q) begin
              end_d   = pos_q;
              known_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
      ST_STCHK: begin
        // duplicate bytes leave the slot alone
        if (!rdata_q[8]) begin
          mem_we    = 1'b1;
          mem_waddr = pos_q[SlotW-1:0];
          mem_wdata = {1'b1, byte_q};
          pend_d    = pend_q + 1'b1;
        end
      end
      ST_ADV: begin
        if (can_adv) begin
          mem_re    = 1'b1;
          mem_raddr = ne_q[SlotW-1:0];
        end
      end
      ST_ADVCHK: begin
        if (rdata_q[8]) begin
          ne_d   = ne_q + 32'd1;
          pend_d = pend_q - 1'b1;
        end
      end
      ST_RDCHK: begin
        rvalid_d  = 1'b1;
        rbyte_d   = rdata_q[7:0];
        mem_we    = 1'b1;
        mem_waddr = fu_q[SlotW-1:0];
        fu_d      = fu_q + 32'd1;
      end
      ST_FIN: begin
        // end reached: next_expected at or past end, within half the index circle
        if (known_q && (pend_q == '0) && !end_gap[31]) begin
          ended_d = 1'b1;
        end
        strobe_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      ne_q     <= '0;
      fu_q     <= '0;
      pend_q   <= '0;
      end_q    <= '0;
      known_q  <= 1'b0;
      ended_q  <= 1'b0;
      rvalid_q <= 1'b0;
      rbyte_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      ne_q     <= ne_d;
      fu_q     <= fu_d;
      pend_q   <= pend_d;
      end_q    <= end_d;
      known_q  <= known_d;
      ended_q  <= ended_d;
      rvalid_q <= rvalid_d;
      rbyte_q  <= rbyte_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    pos_q  <= pos_d;
    byte_q <= byte_d;
    eof_q  <= eof_d;
  end

  assign busy              = state_q != ST_IDLE;
  assign out_strobe_o      = strobe_q;
  assign read_valid_o      = rvalid_q;
  assign read_byte_o       = rbyte_q;
  assign assembled_up_to_o = ne_q;
  assign pending_bytes_o   = 11'(pend_q);
  assign stream_done_o     = ended_q;

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for byte_stream_reassembler_core: a directed table, then random
// segment bytes and reads, checked against an in-bench model of the ring and window;
// typed directed rows against fixed values. Depends on bsr_pkg and the core RTL.
module testbench;
  import bsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;
  // Slowest item: a store that closes a gap in a full ring, or the clearing pass after
  // reset, taken several times over.
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned RandItems  = 620;

  typedef struct packed {
    logic        rd_valid;
    logic [7:0]  rd_byte;
    logic [31:0] asm_idx;
    logic [10:0] pend_cnt;
    logic        done;
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] pos;
    logic [7:0]  val;
    logic        eof;
    logic        typed;
    status_t     want;
  } directed_t;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [31:0] position_i;
  logic [7:0]  value_byte_i;
  logic        eof_i;
  logic        out_strobe_o;
  logic        read_valid_o;
  logic [7:0]  read_byte_o;
  logic [31:0] assembled_up_to_o;
  logic [10:0] pending_bytes_o;
  logic        stream_done_o;

  byte_stream_reassembler_core dut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .op_i,
    .position_i,
    .value_byte_i,
    .eof_i,
    .out_strobe_o,
    .read_valid_o,
    .read_byte_o,
    .assembled_up_to_o,
    .pending_bytes_o,
    .stream_done_o
  );

  // Model state of the ring and the stream window
  logic [7:0]  ring_data [Capacity];
  bit          ring_mark [Capacity];
  logic [31:0] next_idx;
  logic [31:0] unread_idx;
  int unsigned pending_cnt;
  logic [31:0] end_idx;
  bit          end_seen;
  bit          done_seen;

  status_t     status_q [$];
  int          errors;
  int          items_sent;
  int          bytes_landed;
  int          bytes_read;
  int          gap_limit;
  int unsigned idle_cycles;

  directed_t directed_rows [21] = '{
    // read and unused op right after reset
    '{OpRead,   32'd0,          8'h00, 1'b1, 1'b1, '{1'b0, 8'h00, 32'd0, 11'd0, 1'b0}},
    '{OpUnused, 32'hFFFF_FFFF,  8'hFF, 1'b1, 1'b1, '{1'b0, 8'h00, 32'd0, 11'd0, 1'b0}},
    '{OpStore,  32'd0,          8'hFF, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd1, 11'd0, 1'b0}},
    // below the next expected index: dropped
    '{OpStore,  32'd0,          8'h00, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd1, 11'd0, 1'b0}},
    '{OpRead,   32'd0,          8'h00, 1'b0, 1'b1, '{1'b1, 8'hFF, 32'd1, 11'd0, 1'b0}},
    '{OpStore,  32'hFFFF_FFFF,  8'h5A, 1'b0, 1'b1, '{1'b0, 8'h00, 32'd1, 11'd0, 1'b0}},
    '{OpStore,  32'd4,          8'h44, 1'b0, 1'b0, '0},
    '{OpStore,  32'd4,          8'h99, 1'b0, 1'b0, '0},   // duplicate
    '{OpStore,  32'd2,          8'h22, 1'b0, 1'b0, '0},
    '{OpStore,  32'd1025,       8'h77, 1'b0, 1'b0, '0},   // first index past window
    '{OpStore,  32'd3,          8'h33, 1'b0, 1'b0, '0},
    '{OpStore,  32'd1,          8'h11, 1'b0, 1'b0, '0},   // closes the gap
    '{OpRead,   32'd0,          8'h00, 1'b0, 1'b0, '0},
    '{OpStore,  32'h0010_0000,  8'h00, 1'b1, 1'b0, '0},   // eof on dropped byte
    '{OpEmpty,  32'h0020_0000,  8'h00, 1'b1, 1'b0, '0},   // later eof replaces
    '{OpEmpty,  32'd5,          8'h00, 1'b0, 1'b0, '0},
    '{OpRead,   32'd0,          8'h00, 1'b1, 1'b0, '0},
    '{OpRead,   32'd0,          8'h00, 1'b0, 1'b0, '0},
    '{OpRead,   32'd0,          8'h00, 1'b0, 1'b0, '0},
    '{OpRead,   32'd0,          8'h00, 1'b0, 1'b0, '0},   // nothing assembled
    '{OpStore,  32'd5,          8'h80, 1'b0, 1'b0, '0}
  };

  function automatic status_t reassemble_step(input logic [1:0] op, input logic [31:0] pos,
                                              input logic [7:0] val, input logic eof);
    status_t     res;
    logic [31:0] used;
    logic [31:0] room;
    logic [31:0] pos_off;
    int unsigned slot;
    res = '0;
    case (op)
      OpStore: begin
        if (eof) begin
          end_idx  = pos + 32'd1;
          end_seen = 1'b1;
        end
        used    = next_idx - unread_idx;
        room    = (used < Capacity) ? Capacity - used : 32'd0;
        pos_off = pos - next_idx;
        slot    = pos % Capacity;
        if (pos_off < room && !ring_mark[slot]) begin
          ring_data[slot] = val;
          ring_mark[slot] = 1'b1;
          pending_cnt++;
          bytes_landed++;
          while ((next_idx - unread_idx) < Capacity && ring_mark[next_idx % Capacity] &&
                 pending_cnt > 0) begin
            next_idx++;
            pending_cnt--;
          end
        end
      end
      OpRead: begin
        if (unread_idx != next_idx) begin
          slot            = unread_idx % Capacity;
          res.rd_valid    = 1'b1;
          res.rd_byte     = ring_data[slot];
          ring_mark[slot] = 1'b0;
          unread_idx++;
        end
      end
      OpEmpty: begin
        if (eof) begin
          end_idx  = pos;
          end_seen = 1'b1;
        end
      end
      default: ;
    endcase
    // end counts as reached within half the index circle
    if (end_seen && pending_cnt == 0 && (next_idx - end_idx) < 32'h8000_0000)
      done_seen = 1'b1;
    res.asm_idx  = next_idx;
    res.pend_cnt = pending_cnt[10:0];
    res.done     = done_seen;
    return res;
  endfunction

  task automatic issue(input logic [1:0] op, input logic [31:0] pos, input logic [7:0] val,
                       input logic eof, input logic typed, input status_t typed_want);
    status_t pred;
    int      gap;
    gap = (gap_limit == 0) ? 0 : $urandom_range(0, gap_limit);
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start        <= 1'b1;
    op_i         <= op;
    position_i   <= pos;
    value_byte_i <= val;
    eof_i        <= eof;
    do @(posedge clk_i); while (busy);
    pred = reassemble_step(op, pos, val, eof);
    status_q.push_back(typed ? typed_want : pred);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result checker
  always @(posedge clk_i) begin : check_results
    status_t got;
    status_t want;
    if (out_strobe_o) begin
      got = {read_valid_o, read_byte_o, assembled_up_to_o, pending_bytes_o, stream_done_o};
      if (read_valid_o === 1'b1) bytes_read++;
      if (status_q.size() == 0) begin
        $error("result with no item outstanding");
        errors++;
      end else begin
        want = status_q.pop_front();
        if (got.rd_valid !== want.rd_valid) begin
          $error("read_valid: expected %0d, got %0d", want.rd_valid, got.rd_valid);
          errors++;
        end
        if (got.rd_byte !== want.rd_byte) begin
          $error("read_byte: expected %0h, got %0h", want.rd_byte, got.rd_byte);
          errors++;
        end
        if (got.asm_idx !== want.asm_idx) begin
          $error("assembled_up_to: expected %0d, got %0d", want.asm_idx, got.asm_idx);
          errors++;
        end
        if (got.pend_cnt !== want.pend_cnt) begin
          $error("pending_bytes: expected %0d, got %0d", want.pend_cnt, got.pend_cnt);
          errors++;
        end
        if (got.done !== want.done) begin
          $error("stream_done: expected %0d, got %0d", want.done, got.done);
          errors++;
        end
      end
    end
  end

  // watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || out_strobe_o) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int unsigned r;
    int unsigned kind;
    int unsigned read_pct;
    logic [1:0]  op;
    logic [31:0] pos;
    logic        eof;
    rst_ni       = 1'b0;
    start        = 1'b0;
    op_i         = OpStore;
    position_i   = '0;
    value_byte_i = '0;
    eof_i        = 1'b0;
    next_idx     = '0;
    unread_idx   = '0;
    pending_cnt  = 0;
    end_idx      = '0;
    end_seen     = 1'b0;
    done_seen    = 1'b0;
    errors       = 0;
    items_sent   = 0;
    bytes_landed = 0;
    bytes_read   = 0;
    idle_cycles  = 0;
    gap_limit    = 0;
    read_pct     = 25;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i])
      issue(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
            directed_rows[i].eof, directed_rows[i].typed, directed_rows[i].want);
    drain_results();

    for (int n = 0; n < RandItems; n++) begin
      if (n % 60 == 0) begin
        gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 9;
        read_pct  = $urandom_range(5, 50);
      end
      if (n == RandItems / 2) drain_results();
      r   = $urandom_range(0, 99);
      eof = 1'b0;
      if (r < read_pct) begin
        op  = OpRead;
        pos = $urandom;
        eof = 1'($urandom_range(0, 1));
      end else begin
        kind = $urandom_range(0, 99);
        op   = OpStore;
        if (kind < 76) begin
          pos = next_idx + $urandom_range(0, 40);
        end else if (kind < 82) begin
          pos = next_idx - $urandom_range(1, 40);
        end else if (kind < 88) begin
          op  = $urandom_range(0, 1) ? OpEmpty : OpUnused;
          pos = $urandom;
        end else if (kind < 94) begin
          pos = $urandom;
        end else begin
          // end index well ahead: stream stays open
          op  = $urandom_range(0, 1) ? OpEmpty : OpStore;
          pos = next_idx + 32'h0001_0000 + $urandom_range(0, 32'h3FFF_0000);
          eof = 1'b1;
        end
      end
      issue(op, pos, 8'($urandom), eof, 1'b0, '0);
    end

    // fill every gap so nothing is pending, then mark an end already passed
    gap_limit = 3;
    while (pending_cnt != 0) begin
      if ((next_idx - unread_idx) == Capacity) issue(OpRead, '0, '0, 1'b0, 1'b0, '0);
      else issue(OpStore, next_idx, 8'($urandom), 1'b0, 1'b0, '0);
    end
    issue(OpEmpty, next_idx - 32'd3, '0, 1'b1, 1'b0, '0);
    // done stays set while items keep flowing, far edge of the window included
    for (int n = 0; n < 24; n++) begin
      case (n % 4)
        0: issue(OpRead, $urandom, 8'($urandom), 1'b1, 1'b0, '0);
        1: issue(OpStore, next_idx + $urandom_range(0, 2), 8'($urandom), 1'b0, 1'b0, '0);
        2: issue(OpStore, unread_idx + Capacity - 2 + $urandom_range(0, 3), 8'($urandom),
                 1'b0, 1'b0, '0);
        default: issue(OpEmpty, next_idx + 32'h0100_0000, '0, 1'b1, 1'b0, '0);
      endcase
    end
    // last index in the window
    issue(OpStore, unread_idx + Capacity - 32'd1, 8'h01, 1'b0, 1'b0, '0);

    drain_results();
    repeat (20) @(posedge clk_i);
    $display("testbench: %0d items sent, %0d bytes stored in the ring, %0d read back",
             items_sent, bytes_landed, bytes_read);
    $display("testbench: stream assembled to index %0d, end marker %0s",
             next_idx, done_seen ? "reached" : "not reached");
    if (errors == 0) $display("testbench: done, clean");
    else $display("testbench: done, errors");
    $finish;
  end

endmodule
